### hw/rtl/hecag_pkg.sv
package hecag_pkg;

   localparam int MAX_CELLS_DEF = 4096;
   localparam logic [31:0] NO_TIME = 32'hFFFF_FFFF;

   // register indexes on the csr port
   localparam logic [2:0] REG_BASE_ADDRESS  = 3'd0;
   localparam logic [2:0] REG_CELL_SIZE     = 3'd1;
   localparam logic [2:0] REG_CELLS_IN_USE  = 3'd2;
   localparam logic [2:0] REG_FREE_WINDOW   = 3'd3;
   localparam logic [2:0] REG_MALLOC_WINDOW = 3'd4;

   // request op codes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // cell classes
   localparam logic [2:0] CLS_EMPTY    = 3'd0;
   localparam logic [2:0] CLS_OVERHEAD = 3'd1;
   localparam logic [2:0] CLS_LIVE     = 3'd2;
   localparam logic [2:0] CLS_MALLOC   = 3'd3;
   localparam logic [2:0] CLS_FREE     = 3'd4;

   typedef struct packed {
      logic [31:0] live_count;
      logic [63:0] used_bytes;
      logic [63:0] slack_bytes;
      logic [31:0] alloc_stamp;
      logic [31:0] free_stamp;
   } cell_type;

   localparam cell_type CELL_RESET = '{
      live_count: 32'd0, used_bytes: 64'd0, slack_bytes: 64'd0,
      alloc_stamp: NO_TIME, free_stamp: NO_TIME};

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MAP    = 5'b00010,
      ST_READ   = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      MS_IDLE  = 3'b001,
      MS_CHECK = 3'b010,
      MS_DIV   = 3'b100
   } map_state_type;

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   function automatic logic [63:0] floor_sub64(input logic [63:0] a, input logic [63:0] b);
      return (a >= b) ? (a - b) : 64'd0;
   endfunction

   function automatic logic [31:0] stamp_next(input logic [31:0] s, input logic [31:0] t);
      return (s == NO_TIME || t > s) ? t : s;
   endfunction

   function automatic logic [2:0] classify(input cell_type c, input logic [31:0] now,
                                           input logic [31:0] fwin,
                                           input logic [31:0] mwin);
      logic [2:0] cls;
      if (c.free_stamp != NO_TIME && (now - c.free_stamp) < fwin) begin
         cls = CLS_FREE;
      end else if (c.alloc_stamp != NO_TIME && (now - c.alloc_stamp) < mwin) begin
         cls = CLS_MALLOC;
      end else if (c.live_count != 32'd0) begin
         cls = CLS_LIVE;
      end else if (c.slack_bytes != 64'd0) begin
         cls = CLS_OVERHEAD;
      end else begin
         cls = CLS_EMPTY;
      end
      return cls;
   endfunction

endpackage

### hw/rtl/hecag_addr_map.sv
// Address to cell index: range check via one multiply, then restoring
// division one quotient bit per cycle.
module hecag_addr_map #(
   parameter int MAX_CELLS = hecag_pkg::MAX_CELLS_DEF,
   parameter int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
   parameter int CW = $clog2(MAX_CELLS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   address,
   input  logic [63:0]   base_address,
   input  logic [31:0]   cell_size,
   input  logic [CW-1:0] active_cells,
   output logic          done,
   output logic          hit,
   output logic [IW-1:0] index
);
   localparam int RW = 32 + IW;
   localparam int BW = (IW > 1) ? $clog2(IW) : 1;
   localparam int LW = 32 + CW;

   hecag_pkg::map_state_type state_ff, state_in;
   logic [63:0]   diff_ff;
   logic          below_ff;
   logic [LW-1:0] limit_ff;
   logic [RW-1:0] rem_ff;
   logic [IW-1:0] q_ff;
   logic [BW-1:0] bit_ff;
   logic          done_ff, hit_ff;
   logic          miss;
   logic          ge;
   logic [RW-1:0] trial;

   assign miss  = below_ff || (cell_size == 32'd0) || (diff_ff >= 64'(limit_ff));
   assign trial = RW'(cell_size) << bit_ff;
   assign ge    = (rem_ff >> bit_ff) >= RW'(cell_size);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hecag_pkg::MS_IDLE:  if (start) state_in = hecag_pkg::MS_CHECK;
         hecag_pkg::MS_CHECK: state_in = miss ? hecag_pkg::MS_IDLE : hecag_pkg::MS_DIV;
         hecag_pkg::MS_DIV:   if (bit_ff == '0) state_in = hecag_pkg::MS_IDLE;
         default:             state_in = hecag_pkg::MS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hecag_pkg::MS_IDLE;
         done_ff  <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= 1'b0;
         if (state_ff == hecag_pkg::MS_CHECK && miss) begin
            done_ff <= 1'b1;
            hit_ff  <= 1'b0;
         end
         if (state_ff == hecag_pkg::MS_DIV && bit_ff == '0) begin
            done_ff <= 1'b1;
            hit_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == hecag_pkg::MS_IDLE && start) begin
         below_ff <= address < base_address;
         diff_ff  <= address - base_address;
         limit_ff <= LW'(cell_size) * LW'(active_cells);
      end
      if (state_ff == hecag_pkg::MS_CHECK) begin
         rem_ff <= diff_ff[RW-1:0];   // fits once diff is below the limit
         q_ff   <= '0;
         bit_ff <= BW'(IW - 1);
      end
      if (state_ff == hecag_pkg::MS_DIV) begin
         if (ge) begin
            rem_ff <= rem_ff - trial;
         end
         q_ff[bit_ff] <= ge;
         bit_ff <= bit_ff - BW'(1);
      end
   end

   assign done  = done_ff;
   assign hit   = hit_ff;
   assign index = q_ff;

endmodule

### hw/rtl/hecag_cell_mem.sv
module hecag_cell_mem #(
   parameter int DEPTH = hecag_pkg::MAX_CELLS_DEF,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AW-1:0]       waddr,
   input  hecag_pkg::cell_type wdata,
   input  logic                re,
   input  logic [AW-1:0]       raddr,
   output hecag_pkg::cell_type rdata
);
   hecag_pkg::cell_type mem [DEPTH];
   hecag_pkg::cell_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/heap_event_cell_aggregator_unit.sv
// Heap event cell aggregator.
// req_* carries one heap event transaction: alloc, free, query or clear (op in
// req_tuser). Every request transaction yields exactly one rsp_* transaction
// with the addressed cell after update plus the global live totals.
// csr_* writes the geometry and window registers; a write that changes base,
// cell size or cell count wipes all cells and totals.
// From request accept to rsp_tvalid: an alloc/free passes the map state, where
// the bit-serial address divider runs, then read, update and done on a hit;
// an alloc/free miss goes from map to done, an in-range query through read,
// update and done, an out-of-range query or a clear straight to done. One event
// is in flight at a time; the next request is taken once the response is loaded.
// Cells live in one synchronous memory; each event is read, modified and
// written back before the next event is taken, so no forwarding is needed.
// Reset, a clear op and a geometry change start a wipe pass over all MAX_CELLS
// cells (4096 by default) during which req_tready is low.
// The response sits in an output register: a stalled receiver holds it, and
// the next request is taken meanwhile, but the block waits before its own
// response if the previous one has not been taken yet.
module heap_event_cell_aggregator_unit #(
   parameter int MAX_CELLS = hecag_pkg::MAX_CELLS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request
   input  logic         req_tvalid,
   output logic         req_tready,
   // [63:0] address, [95:64] req_size, [127:96] usable_size,
   // [159:128] now_ms, [171:160] cell_index, [175:172] zero
   input  logic [175:0] req_tdata,
   // [1:0] op
   input  logic [1:0]   req_tuser,
   // response
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] live_count, [95:32] cell usable bytes, [159:96] cell slack bytes,
   // [191:160] last_alloc_stamp, [223:192] last_free_stamp,
   // [287:224] total_live_count, [351:288] total_live_bytes
   output logic [351:0] rsp_tdata,
   // [0] hit, [3:1] cell_class
   output logic [3:0]   rsp_tuser,
   // register writes
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int CW = $clog2(MAX_CELLS + 1);

   // configuration
   logic [63:0] base_ff;
   logic [31:0] csize_ff;
   logic [12:0] ciu_ff;
   logic [31:0] fwin_ff, mwin_ff;
   logic [CW-1:0] active;

   // item in flight
   hecag_pkg::state_type state_ff, state_in;
   logic [1:0]  op_ff;
   logic [31:0] req_size_ff, usable_ff, now_ff;
   logic        hit_ff;
   logic [IW-1:0] idx_ff;
   hecag_pkg::cell_type cell_ff, cell_new, rd_cell;
   logic [63:0] over;

   // totals
   logic [63:0] tot_cnt_ff, tot_bytes_ff;

   // wipe pass
   logic          wipe_ff;
   logic [IW-1:0] wipe_cnt_ff;

   // output register
   logic         rsp_valid_ff;
   logic [351:0] rsp_data_ff;
   logic [3:0]   rsp_user_ff;

   logic map_start, map_done, map_hit;
   logic [IW-1:0] map_idx;
   logic mem_we, mem_re;
   logic [IW-1:0] mem_waddr, mem_raddr;
   hecag_pkg::cell_type mem_wdata;
   logic accept, q_in_range, slot_free, geo_change;

   assign active = (32'(ciu_ff) > 32'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(ciu_ff);
   assign req_tready = (state_ff == hecag_pkg::ST_IDLE) && !wipe_ff;
   assign accept = req_tvalid && req_tready;
   assign q_in_range = 32'(req_tdata[171:160]) < 32'(active);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign over = (usable_ff > req_size_ff) ? 64'(usable_ff - req_size_ff) : 64'd0;

   assign map_start = accept && (req_tuser == hecag_pkg::OP_ALLOC ||
                                 req_tuser == hecag_pkg::OP_FREE);

   hecag_addr_map #(.MAX_CELLS(MAX_CELLS), .IW(IW), .CW(CW)) u_map (
      .clock       (clock),
      .reset       (reset),
      .start       (map_start),
      .address     (req_tdata[63:0]),
      .base_address(base_ff),
      .cell_size   (csize_ff),
      .active_cells(active),
      .done        (map_done),
      .hit         (map_hit),
      .index       (map_idx)
   );

   // read port: query reads at accept, alloc/free once mapped
   assign mem_re    = (accept && req_tuser == hecag_pkg::OP_QUERY && q_in_range) ||
                      (state_ff == hecag_pkg::ST_MAP && map_done && map_hit);
   assign mem_raddr = (state_ff == hecag_pkg::ST_MAP) ? map_idx : IW'(req_tdata[171:160]);

   // write port: wipe pass or read-modify-write of alloc/free
   assign mem_we    = wipe_ff || (state_ff == hecag_pkg::ST_UPDATE && op_ff != hecag_pkg::OP_QUERY);
   assign mem_waddr = wipe_ff ? wipe_cnt_ff : idx_ff;
   assign mem_wdata = wipe_ff ? hecag_pkg::CELL_RESET : cell_new;

   hecag_cell_mem #(.DEPTH(MAX_CELLS), .AW(IW)) u_mem (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re   (mem_re),
      .raddr(mem_raddr),
      .rdata(rd_cell)
   );

   // cell update
   always_comb begin
      cell_new = rd_cell;
      if (op_ff == hecag_pkg::OP_ALLOC) begin
         if (rd_cell.live_count != hecag_pkg::NO_TIME) begin
            cell_new.live_count = rd_cell.live_count + 32'd1;
         end
         cell_new.used_bytes  = hecag_pkg::sat_add64(rd_cell.used_bytes, 64'(usable_ff));
         cell_new.slack_bytes = hecag_pkg::sat_add64(rd_cell.slack_bytes, over);
         cell_new.alloc_stamp = hecag_pkg::stamp_next(rd_cell.alloc_stamp, now_ff);
      end else if (op_ff == hecag_pkg::OP_FREE) begin
         if (rd_cell.live_count != 32'd0) begin
            cell_new.live_count  = rd_cell.live_count - 32'd1;
            cell_new.used_bytes  = hecag_pkg::floor_sub64(rd_cell.used_bytes,
                                                          64'(usable_ff));
            cell_new.slack_bytes = hecag_pkg::floor_sub64(rd_cell.slack_bytes, over);
         end
         cell_new.free_stamp = hecag_pkg::stamp_next(rd_cell.free_stamp, now_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hecag_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  hecag_pkg::OP_ALLOC, hecag_pkg::OP_FREE: state_in = hecag_pkg::ST_MAP;
                  hecag_pkg::OP_QUERY:
                     state_in = q_in_range ? hecag_pkg::ST_READ : hecag_pkg::ST_DONE;
                  default: state_in = hecag_pkg::ST_DONE;
               endcase
            end
         end
         hecag_pkg::ST_MAP: begin
            if (map_done) begin
               state_in = map_hit ? hecag_pkg::ST_READ : hecag_pkg::ST_DONE;
            end
         end
         hecag_pkg::ST_READ:   state_in = hecag_pkg::ST_UPDATE;
         hecag_pkg::ST_UPDATE: state_in = hecag_pkg::ST_DONE;
         hecag_pkg::ST_DONE:   if (slot_free) state_in = hecag_pkg::ST_IDLE;
         default:              state_in = hecag_pkg::ST_IDLE;
      endcase
   end

   assign geo_change = csr_we &&
      ((csr_index == hecag_pkg::REG_BASE_ADDRESS && csr_wdata != base_ff) ||
       (csr_index == hecag_pkg::REG_CELL_SIZE && csr_wdata[31:0] != csize_ff) ||
       (csr_index == hecag_pkg::REG_CELLS_IN_USE && csr_wdata[12:0] != ciu_ff));

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hecag_pkg::ST_IDLE;
         base_ff      <= 64'd0;
         csize_ff     <= 32'd16;
         ciu_ff       <= 13'd0;
         fwin_ff      <= 32'd500;
         mwin_ff      <= 32'd250;
         tot_cnt_ff   <= 64'd0;
         tot_bytes_ff <= 64'd0;
         wipe_ff      <= 1'b1;
         wipe_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (wipe_ff) begin
            wipe_cnt_ff <= wipe_cnt_ff + IW'(1);
            if (32'(wipe_cnt_ff) == 32'(MAX_CELLS - 1)) begin
               wipe_ff <= 1'b0;
            end
         end

         if (csr_we) begin
            unique case (csr_index)
               hecag_pkg::REG_BASE_ADDRESS:  base_ff  <= csr_wdata;
               hecag_pkg::REG_CELL_SIZE:     csize_ff <= csr_wdata[31:0];
               hecag_pkg::REG_CELLS_IN_USE:  ciu_ff   <= csr_wdata[12:0];
               hecag_pkg::REG_FREE_WINDOW:   fwin_ff  <= csr_wdata[31:0];
               hecag_pkg::REG_MALLOC_WINDOW: mwin_ff  <= csr_wdata[31:0];
               default: ;
            endcase
         end

         // totals follow the committed cell update
         if (state_ff == hecag_pkg::ST_UPDATE) begin
            if (op_ff == hecag_pkg::OP_ALLOC) begin
               tot_cnt_ff   <= hecag_pkg::sat_add64(tot_cnt_ff, 64'd1);
               tot_bytes_ff <= hecag_pkg::sat_add64(tot_bytes_ff, 64'(usable_ff));
            end else if (op_ff == hecag_pkg::OP_FREE && rd_cell.live_count != 32'd0) begin
               if (tot_cnt_ff != 64'd0) begin
                  tot_cnt_ff <= tot_cnt_ff - 64'd1;
               end
               tot_bytes_ff <= hecag_pkg::floor_sub64(tot_bytes_ff, 64'(usable_ff));
            end
         end

         if ((accept && req_tuser == hecag_pkg::OP_CLEAR) || geo_change) begin
            tot_cnt_ff   <= 64'd0;
            tot_bytes_ff <= 64'd0;
            wipe_ff      <= 1'b1;
            wipe_cnt_ff  <= '0;
         end

         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == hecag_pkg::ST_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_tuser;
         req_size_ff <= req_tdata[95:64];
         usable_ff   <= req_tdata[127:96];
         now_ff      <= req_tdata[159:128];
         hit_ff      <= (req_tuser == hecag_pkg::OP_QUERY) && q_in_range;
         idx_ff      <= IW'(req_tdata[171:160]);
      end
      if (state_ff == hecag_pkg::ST_MAP && map_done) begin
         hit_ff <= map_hit;
         idx_ff <= map_idx;
      end
      if (state_ff == hecag_pkg::ST_UPDATE) begin
         cell_ff <= cell_new;
      end
      if (state_ff == hecag_pkg::ST_DONE && slot_free) begin
         if (hit_ff) begin
            rsp_user_ff <= {hecag_pkg::classify(cell_ff, now_ff, fwin_ff, mwin_ff), 1'b1};
            rsp_data_ff[223:0] <= {cell_ff.free_stamp, cell_ff.alloc_stamp,
                                   cell_ff.slack_bytes, cell_ff.used_bytes,
                                   cell_ff.live_count};
         end else begin
            rsp_user_ff <= {hecag_pkg::CLS_EMPTY, 1'b0};
            rsp_data_ff[223:0] <= '0;
         end
         rsp_data_ff[351:224] <= {tot_bytes_ff, tot_cnt_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### tb/sv/tb_heap_event_cell_aggregator_unit.sv
module tb_heap_event_cell_aggregator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_CELLS = hecag_pkg::MAX_CELLS_DEF;
   // margin allowed after the last expected response
   localparam int SETTLE_CYCLES = 40;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // [63:0] address, [95:64] req_size, [127:96] usable_size,
   // [159:128] now_ms, [171:160] cell_index, [175:172] zero
   logic [175:0] req_tdata;
   // [1:0] op
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // [31:0] live_count, [95:32] cell usable bytes, [159:96] cell slack bytes,
   // [191:160] last_alloc_stamp, [223:192] last_free_stamp,
   // [287:224] total_live_count, [351:288] total_live_bytes
   logic [351:0] rsp_tdata;
   // [0] hit, [3:1] cell_class
   logic [3:0]   rsp_tuser;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [63:0]  csr_wdata;

   heap_event_cell_aggregator_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // one expected response transaction
   typedef struct {
      logic                hit;
      logic [2:0]          cls;
      hecag_pkg::cell_type entry;
      logic [63:0]         total_count;
      logic [63:0]         total_bytes;
   } cell_report_type;

   // ---------------- shadow copy of the block ----------------
   logic [63:0] sh_base;
   logic [31:0] sh_cell_bytes;
   logic [12:0] sh_cells;
   logic [31:0] sh_free_win;
   logic [31:0] sh_malloc_win;
   hecag_pkg::cell_type sh_cell [N_CELLS];
   logic [63:0] sh_total_count;
   logic [63:0] sh_total_bytes;

   cell_report_type pending_reports[$];

   int errors;
   int n_events, n_hits, n_misses, n_clears, n_cfg_writes;
   int class_seen [5];

   // stimulus knobs
   int req_idle_pct;
   int rsp_stall_pct;
   int holdoff_cycles;
   logic [31:0] wall_ms;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb_heap_event_cell_aggregator_unit: errors");
      $finish;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h (t=%0t)", what, got, want, $realtime);
      errors++;
   endtask

   // wipe every cell and both totals
   function automatic void wipe_shadow();
      for (int i = 0; i < N_CELLS; i++) sh_cell[i] = hecag_pkg::CELL_RESET;
      sh_total_count = '0;
      sh_total_bytes = '0;
   endfunction

   function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic [63:0] sub_floor(input logic [63:0] a, input logic [63:0] b);
      return (a >= b) ? a - b : 64'd0;
   endfunction

   function automatic logic [12:0] grid_cells();
      return (sh_cells > N_CELLS) ? 13'(N_CELLS) : sh_cells;
   endfunction

   // newer time wins; a slot holding "no time" takes anything
   function automatic logic [31:0] newer_stamp(input logic [31:0] s, input logic [31:0] t);
      return (s == hecag_pkg::NO_TIME || t > s) ? t : s;
   endfunction

   function automatic logic recent(input logic [31:0] stamp, input logic [31:0] now,
                                   input logic [31:0] win);
      logic [31:0] age;
      age = now - stamp;
      return (stamp != hecag_pkg::NO_TIME) && (age < win);
   endfunction

   function automatic logic [2:0] class_at(input hecag_pkg::cell_type c,
                                           input logic [31:0] now);
      if (recent(c.free_stamp, now, sh_free_win)) return hecag_pkg::CLS_FREE;
      if (recent(c.alloc_stamp, now, sh_malloc_win)) return hecag_pkg::CLS_MALLOC;
      if (c.live_count != 0) return hecag_pkg::CLS_LIVE;
      if (c.slack_bytes != 0) return hecag_pkg::CLS_OVERHEAD;
      return hecag_pkg::CLS_EMPTY;
   endfunction

   // address -> cell index; returns 0 on a miss
   function automatic logic locate_cell(input logic [63:0] addr, output int idx);
      logic [63:0] q;
      idx = 0;
      if (sh_cell_bytes == 0 || addr < sh_base) return 1'b0;
      q = (addr - sh_base) / {32'd0, sh_cell_bytes};
      if (q >= {51'd0, grid_cells()}) return 1'b0;
      idx = int'(q);
      return 1'b1;
   endfunction

   // apply one heap event to the shadow state and form the response it causes
   function automatic cell_report_type apply_heap_event(
         input logic [1:0] op, input logic [63:0] addr, input logic [31:0] rsize,
         input logic [31:0] usize, input logic [31:0] now, input logic [11:0] qidx);
      cell_report_type r;
      int idx;
      logic hit;
      logic [31:0] over;
      over = (usize > rsize) ? usize - rsize : 32'd0;
      hit = 1'b0;
      idx = 0;
      case (op)
         hecag_pkg::OP_ALLOC: begin
            hit = locate_cell(addr, idx);
            if (hit) begin
               if (sh_cell[idx].live_count != hecag_pkg::NO_TIME) sh_cell[idx].live_count++;
               sh_cell[idx].used_bytes = add_sat(sh_cell[idx].used_bytes, {32'd0, usize});
               sh_cell[idx].slack_bytes =
                  add_sat(sh_cell[idx].slack_bytes, {32'd0, over});
               sh_cell[idx].alloc_stamp = newer_stamp(sh_cell[idx].alloc_stamp, now);
               sh_total_count = add_sat(sh_total_count, 64'd1);
               sh_total_bytes = add_sat(sh_total_bytes, {32'd0, usize});
            end
         end
         hecag_pkg::OP_FREE: begin
            hit = locate_cell(addr, idx);
            if (hit) begin
               // freeing an empty cell only moves its free stamp
               if (sh_cell[idx].live_count != 0) begin
                  sh_cell[idx].live_count--;
                  sh_cell[idx].used_bytes = sub_floor(sh_cell[idx].used_bytes, {32'd0, usize});
                  sh_cell[idx].slack_bytes =
                     sub_floor(sh_cell[idx].slack_bytes, {32'd0, over});
                  if (sh_total_count != 0) sh_total_count--;
                  sh_total_bytes = sub_floor(sh_total_bytes, {32'd0, usize});
               end
               sh_cell[idx].free_stamp = newer_stamp(sh_cell[idx].free_stamp, now);
            end
         end
         hecag_pkg::OP_QUERY: begin
            if ({1'b0, qidx} < grid_cells()) begin
               hit = 1'b1;
               idx = int'(qidx);
            end
         end
         default: wipe_shadow();
      endcase
      r.hit = hit;
      if (hit) begin
         r.cls   = class_at(sh_cell[idx], now);
         r.entry = sh_cell[idx];
      end else begin
         r.cls   = hecag_pkg::CLS_EMPTY;
         r.entry = '0;
      end
      r.total_count = sh_total_count;
      r.total_bytes = sh_total_bytes;
      return r;
   endfunction

   // ---------------- receiver ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_cycles > 0) begin
         holdoff_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // response checker: every accepted transaction against the oldest prediction
   always @(posedge clock) begin
      cell_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            report("unexpected response", {rsp_tuser, rsp_tdata[59:0]}, 64'd0);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tuser[0] !== want.hit)
               report("hit", 64'(rsp_tuser[0]), 64'(want.hit));
            if (rsp_tuser[3:1] !== want.cls)
               report("cell_class", 64'(rsp_tuser[3:1]), 64'(want.cls));
            if (rsp_tdata[31:0] !== want.entry.live_count)
               report("live_count", 64'(rsp_tdata[31:0]), 64'(want.entry.live_count));
            if (rsp_tdata[95:32] !== want.entry.used_bytes)
               report("cell usable bytes", rsp_tdata[95:32], want.entry.used_bytes);
            if (rsp_tdata[159:96] !== want.entry.slack_bytes)
               report("cell slack bytes", rsp_tdata[159:96], want.entry.slack_bytes);
            if (rsp_tdata[191:160] !== want.entry.alloc_stamp)
               report("last_alloc_stamp", 64'(rsp_tdata[191:160]),
                      64'(want.entry.alloc_stamp));
            if (rsp_tdata[223:192] !== want.entry.free_stamp)
               report("last_free_stamp", 64'(rsp_tdata[223:192]),
                      64'(want.entry.free_stamp));
            if (rsp_tdata[287:224] !== want.total_count)
               report("total_live_count", rsp_tdata[287:224], want.total_count);
            if (rsp_tdata[351:288] !== want.total_bytes)
               report("total_live_bytes", rsp_tdata[351:288], want.total_bytes);
         end
      end
   end

   // ---------------- sender ----------------
   // Leaves req_tvalid high after the handshake so back-to-back transactions
   // need no extra NBA; anything else that waits calls release_req first.
   task automatic send_event(input logic [1:0] op, input logic [63:0] addr,
                             input logic [31:0] rsize, input logic [31:0] usize,
                             input logic [31:0] now, input logic [11:0] qidx);
      cell_report_type r;
      int gap;
      gap = ($urandom_range(0, 99) < req_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, qidx, now, usize, rsize, addr};
      do @(posedge clock); while (!req_tready);
      r = apply_heap_event(op, addr, rsize, usize, now, qidx);
      pending_reports.push_back(r);
      n_events++;
      if (op == hecag_pkg::OP_CLEAR) n_clears++;
      if (r.hit) begin
         n_hits++;
         class_seen[r.cls]++;
      end else begin
         n_misses++;
      end
   endtask

   task automatic release_req();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // sender pauses until every expected response has come back
   task automatic drain();
      release_req();
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write; only called after drain()
   task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      n_cfg_writes++;
      case (index)
         hecag_pkg::REG_BASE_ADDRESS: if (value != sh_base) begin
            sh_base = value;
            wipe_shadow();
         end
         hecag_pkg::REG_CELL_SIZE: if (value[31:0] != sh_cell_bytes) begin
            sh_cell_bytes = value[31:0];
            wipe_shadow();
         end
         hecag_pkg::REG_CELLS_IN_USE: if (value[12:0] != sh_cells) begin
            sh_cells = value[12:0];
            wipe_shadow();
         end
         hecag_pkg::REG_FREE_WINDOW:   sh_free_win = value[31:0];
         hecag_pkg::REG_MALLOC_WINDOW: sh_malloc_win = value[31:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(input logic [63:0] base, input logic [31:0] csize,
                               input logic [12:0] cells);
      drain();
      write_reg(hecag_pkg::REG_BASE_ADDRESS, base);
      write_reg(hecag_pkg::REG_CELL_SIZE, {32'd0, csize});
      write_reg(hecag_pkg::REG_CELLS_IN_USE, {51'd0, cells});
   endtask

   function automatic logic [63:0] cell_addr(input int idx, input logic [31:0] offset);
      return sh_base + 64'(idx) * {32'd0, sh_cell_bytes} + {32'd0, offset};
   endfunction

   // one random heap event, mostly well-formed addresses inside the grid
   task automatic random_event();
      logic [1:0]  op;
      logic [63:0] addr;
      logic [31:0] rsize, usize, now, off;
      logic [11:0] qidx;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 42)      op = hecag_pkg::OP_ALLOC;
      else if (pick < 72) op = hecag_pkg::OP_FREE;
      else if (pick < 97) op = hecag_pkg::OP_QUERY;
      else                op = hecag_pkg::OP_CLEAR;
      off = (sh_cell_bytes == 0) ? 32'd0 : $urandom % sh_cell_bytes;
      if ($urandom_range(0, 99) < 85)
         addr = cell_addr($urandom_range(0, int'(grid_cells()) + 1), off);
      else
         addr = {$urandom, $urandom};
      rsize = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 512);
      usize = ($urandom_range(0, 9) == 0) ? $urandom : rsize + $urandom_range(0, 48);
      wall_ms += $urandom_range(0, 200);
      now = ($urandom_range(0, 19) == 0) ? $urandom : wall_ms;
      qidx = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                          : 12'($urandom_range(0, int'(grid_cells()) + 1));
      send_event(op, addr, rsize, usize, now, qidx);
   endtask

   task automatic random_geometry();
      logic [63:0] base;
      base = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
      set_geometry(base, 32'($urandom_range(1, 64)), 13'($urandom_range(1, 40)));
      write_reg(hecag_pkg::REG_FREE_WINDOW, 64'($urandom_range(0, 1500)));
      write_reg(hecag_pkg::REG_MALLOC_WINDOW, 64'($urandom_range(0, 1500)));
   endtask

   // ---------------- tests ----------------

   // out of reset the grid is invalid: everything misses
   task automatic test_reset_state();
      send_event(hecag_pkg::OP_ALLOC, 64'd0, 32'd8, 32'd16, 32'd1, 12'd0);
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd1, 12'd0);
      send_event(hecag_pkg::OP_FREE, 64'd16, 32'd8, 32'd16, 32'd2, 12'd0);
      drain();
   endtask

   // per-op behavior, classes, grid edges and stamp rules on a tiny grid
   task automatic test_event_ops();
      set_geometry(64'h1000, 32'd16, 13'd8);
      write_reg(hecag_pkg::REG_FREE_WINDOW, 64'd100);
      write_reg(hecag_pkg::REG_MALLOC_WINDOW, 64'd50);
      send_event(hecag_pkg::OP_ALLOC, 64'h1000, 32'd10, 32'd16, 32'd1000, 12'd0); // first cell
      send_event(hecag_pkg::OP_ALLOC, 64'h0FFF, 32'd10, 32'd16, 32'd1000, 12'd0); // below base
      send_event(hecag_pkg::OP_ALLOC, 64'h107F, 32'd10, 32'd10, 32'd1001, 12'd0); // last cell
      send_event(hecag_pkg::OP_ALLOC, 64'h1080, 32'd10, 32'd16, 32'd1001, 12'd0); // past grid
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd1020, 12'd0);  // recent malloc
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd1200, 12'd0);  // live
      send_event(hecag_pkg::OP_FREE, 64'h1010, 32'd1, 32'd2, 32'd1300, 12'd0); // empty cell
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd1350, 12'd1);  // recent free
      // free with no overhead leaves the overhead bytes: overhead class later
      send_event(hecag_pkg::OP_FREE, 64'h1008, 32'd16, 32'd16, 32'd1400, 12'd0);
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd2000, 12'd0);
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd2000, 12'd1);  // empty
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd2000, 12'd8);  // out of range
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd2000, 12'hFFF);
      // older stamp is ignored, then "no time" as an event time
      send_event(hecag_pkg::OP_ALLOC, 64'h1070, 32'hFFFF_FFFF, 32'd0, 32'd5, 12'd0);
      send_event(hecag_pkg::OP_ALLOC, 64'h1070, 32'd0, 32'hFFFF_FFFF, hecag_pkg::NO_TIME,
                 12'd0);
      send_event(hecag_pkg::OP_FREE, 64'h1070, 32'd0, 32'hFFFF_FFFF, 32'd0, 12'd0);
      send_event(hecag_pkg::OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 32'd2, 32'd3, 12'd0);
      send_event(hecag_pkg::OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1, '1, 12'hFFF);
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd2100, 12'd7);
      drain();
   endtask

   // register extremes, no-change writes, bad indexes
   task automatic test_register_extremes();
      send_event(hecag_pkg::OP_ALLOC, 64'h1020, 32'd4, 32'd8, 32'd3000, 12'd0);
      drain();
      write_reg(hecag_pkg::REG_CELL_SIZE, 64'd16);       // same value: no wipe
      write_reg(3'd5, 64'hDEAD);
      write_reg(3'd6, 64'd0);
      write_reg(3'd7, '1);
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd3001, 12'd2);
      drain();
      write_reg(hecag_pkg::REG_FREE_WINDOW, 64'd0);
      write_reg(hecag_pkg::REG_MALLOC_WINDOW, 64'hFFFF_FFFF_FFFF_FFFF);
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd3001, 12'd2);
      drain();
      write_reg(hecag_pkg::REG_FREE_WINDOW, 64'hFFFF_FFFF);
      // count above the maximum saturates
      set_geometry(64'd0, 32'd1, 13'h1FFF);
      send_event(hecag_pkg::OP_ALLOC, 64'd4095, 32'd1, 32'd1, 32'd10, 12'd0);
      send_event(hecag_pkg::OP_ALLOC, 64'd4096, 32'd1, 32'd1, 32'd10, 12'd0);
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd11, 12'hFFF);
      set_geometry(64'd0, 32'd1, 13'd4096);
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd12, 12'hFFF);
      set_geometry(64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF, 13'd2);
      send_event(hecag_pkg::OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd9, 32'd20, 12'd0);
      send_event(hecag_pkg::OP_ALLOC, 64'hFFFF_FFFF_0000_0000, 32'd9, 32'd0, 32'd20, 12'd0);
      drain();
      write_reg(hecag_pkg::REG_CELL_SIZE, 64'd0);        // every address misses
      send_event(hecag_pkg::OP_ALLOC, 64'hFFFF_FFFF_0000_0000, 32'd1, 32'd2, 32'd21, 12'd0);
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd22, 12'd1);
      set_geometry(64'd0, 32'd16, 13'd0);
      send_event(hecag_pkg::OP_QUERY, 64'd0, 32'd0, 32'd0, 32'd23, 12'd0);
      drain();
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      random_geometry();
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) random_geometry();
         random_event();
      end
      drain();
   endtask

   // receiver stops for a long stretch while the sender keeps offering
   task automatic test_receiver_holdoff();
      random_geometry();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      holdoff_cycles = 300;
      for (int i = 0; i < 40; i++) random_event();
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = hecag_pkg::OP_ALLOC;
      csr_we = 1'b0;
      csr_index = hecag_pkg::REG_BASE_ADDRESS;
      csr_wdata = '0;
      errors = 0;
      n_events = 0; n_hits = 0; n_misses = 0; n_clears = 0; n_cfg_writes = 0;
      foreach (class_seen[i]) class_seen[i] = 0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      holdoff_cycles = 0;
      wall_ms = 32'd5000;
      sh_base = '0;
      sh_cell_bytes = 32'd16;
      sh_cells = '0;
      sh_free_win = 32'd500;
      sh_malloc_win = 32'd250;
      wipe_shadow();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_event_ops();
      test_register_extremes();
      test_random_traffic(200, 8, 68);
      test_random_traffic(200, 68, 8);
      test_random_traffic(200, 0, 0);
      test_receiver_holdoff();
      drain();

      $display("covered %0d transactions: %0d hits, %0d misses, %0d clears, %0d csr writes",
               n_events, n_hits, n_misses, n_clears, n_cfg_writes);
      $display("hit classes empty/overhead/live/malloc/free: %0d/%0d/%0d/%0d/%0d",
               class_seen[0], class_seen[1], class_seen[2], class_seen[3], class_seen[4]);
      if (errors == 0) begin
         $display("tb_heap_event_cell_aggregator_unit: clean");
      end else begin
         $display("tb_heap_event_cell_aggregator_unit: errors");
      end
      $finish;
   end

endmodule
